// ===== sv/ccrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccrc_pkg
// Shared types and codes for the configurable CRC engine: algorithm codes,
// configuration register indexes and the configuration record.
// ----------------------------------------------------------------------------
package ccrc_pkg;

    localparam int CRC_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    // Algorithm codes
    typedef enum logic [1:0] {
        ALG_XOR   = 2'd0,
        ALG_CRC8  = 2'd1,
        ALG_CRC16 = 2'd2,
        ALG_CRC32 = 2'd3
    } t_alg;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALG    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FXOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF_IN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF_OUT = 3'd5;

    // Reset values of the configuration registers
    localparam logic [CRC_W-1:0] RST_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] RST_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] RST_FXOR = 32'hFFFF_FFFF;

    typedef struct packed {
        t_alg             alg;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init;
        logic [CRC_W-1:0] fxor;
        logic             ref_in;
        logic             ref_out;
    } t_cfg;

endpackage

// ===== sv/ccrc_stream_if.sv =====
// ----------------------------------------------------------------------------
// ccrc_stream_if
// Valid/ready channels of the CRC engine: the message byte channel and the
// checksum result channel.
// ----------------------------------------------------------------------------
interface ccrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ccrc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum_value;

    modport source (output valid, output checksum_value, input ready);
    modport sink   (input valid, input checksum_value, output ready);
endinterface

// ===== sv/ccrc_byte_step.sv =====
// ----------------------------------------------------------------------------
// ccrc_byte_step
// Absorbs one message byte into the accumulator for the selected algorithm
// and forms the finished checksum from the updated accumulator.
// ----------------------------------------------------------------------------
module ccrc_byte_step
    import ccrc_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [CRC_W-1:0]  i_acc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [CRC_W-1:0]  o_acc_next,
    output logic [CRC_W-1:0]  o_checksum
);

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31-i];
        end
        return r;
    endfunction

    logic [7:0]  a8;
    logic [15:0] a16;
    logic [31:0] a32;
    logic [31:0] poly_rev;
    logic [7:0]  byte_in;

    // Eight unrolled bit steps per CRC algorithm, then finish
    always_comb begin
        a8       = '0;
        a16      = '0;
        a32      = '0;
        poly_rev = rev32(i_cfg.poly);
        byte_in  = i_cfg.ref_in ? rev8(i_byte) : i_byte;
        unique case (i_cfg.alg)
            ALG_XOR: begin
                a8         = i_acc[7:0] ^ i_byte;
                o_acc_next = {24'd0, a8};
                o_checksum = {24'd0, a8};
            end
            ALG_CRC8: begin
                a8 = i_acc[7:0] ^ byte_in;
                for (int i = 0; i < 8; i++) begin
                    a8 = a8[7] ? ({a8[6:0], 1'b0} ^ i_cfg.poly[7:0]) : {a8[6:0], 1'b0};
                end
                o_acc_next = {24'd0, a8};
                o_checksum = {24'd0, (i_cfg.ref_out ? rev8(a8) : a8) ^ i_cfg.fxor[7:0]};
            end
            ALG_CRC16: begin
                a16 = i_acc[15:0] ^ {byte_in, 8'd0};
                for (int i = 0; i < 8; i++) begin
                    a16 = a16[15] ? ({a16[14:0], 1'b0} ^ i_cfg.poly[15:0])
                                  : {a16[14:0], 1'b0};
                end
                o_acc_next = {16'd0, a16};
                o_checksum = {16'd0, (i_cfg.ref_out ? rev16(a16) : a16) ^ i_cfg.fxor[15:0]};
            end
            ALG_CRC32: begin
                // CRC32 reflects the byte when reflect_in is clear
                a32 = i_acc ^ {24'd0, (i_cfg.ref_in ? i_byte : rev8(i_byte))};
                for (int i = 0; i < 8; i++) begin
                    a32 = a32[0] ? ({1'b0, a32[31:1]} ^ poly_rev) : {1'b0, a32[31:1]};
                end
                o_acc_next = a32;
                o_checksum = (i_cfg.ref_out ? a32 : rev32(a32)) ^ i_cfg.fxor;
            end
            default: begin
                o_acc_next = i_acc;
                o_checksum = '0;
            end
        endcase
    end

endmodule

// ===== sv/configurable_crc_engine.sv =====
// ----------------------------------------------------------------------------
// configurable_crc_engine
// Data path: an accepted byte enters the input register, then updates the
// accumulator; only end-of-message bytes load the result register.
// Throughput: one byte per cycle, with a whole byte absorbed per accumulator
// update; a stalled result holds only a last byte behind it, stalling input.
// Reset: synchronous, active low; registers return to CRC32 defaults and the
// accumulator to 0xFFFFFFFF. Config writes reload the accumulator.
// ----------------------------------------------------------------------------
module configurable_crc_engine
    import ccrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ccrc_in_if.sink              i_in,
    ccrc_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CRC_W-1:0]     i_cfg_data
);

    function automatic logic [CRC_W-1:0] start_value(input t_cfg c);
        logic [CRC_W-1:0] s;
        unique case (c.alg)
            ALG_XOR:   s = '0;
            ALG_CRC8:  s = {24'd0, c.init[7:0]};
            ALG_CRC16: s = {16'd0, c.init[15:0]};
            ALG_CRC32: s = c.init;
            default:   s = c.init;
        endcase
        return s;
    endfunction

    t_cfg              r_cfg, n_cfg;
    logic              cfg_hit;
    logic [CRC_W-1:0]  r_acc;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_eom;
    logic              r_out_valid;
    logic [CRC_W-1:0]  r_out_value;
    logic [CRC_W-1:0]  acc_next;
    logic [CRC_W-1:0]  checksum;
    logic              s1_adv;

    // Decode configuration writes
    always_comb begin
        n_cfg   = r_cfg;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            cfg_hit = 1'b1;
            unique case (i_cfg_index)
                CFG_IDX_ALG:     n_cfg.alg     = t_alg'(i_cfg_data[1:0]);
                CFG_IDX_POLY:    n_cfg.poly    = i_cfg_data;
                CFG_IDX_INIT:    n_cfg.init    = i_cfg_data;
                CFG_IDX_FXOR:    n_cfg.fxor    = i_cfg_data;
                CFG_IDX_REF_IN:  n_cfg.ref_in  = i_cfg_data[0];
                CFG_IDX_REF_OUT: n_cfg.ref_out = i_cfg_data[0];
                default:         cfg_hit       = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alg     <= ALG_CRC32;
            r_cfg.poly    <= RST_POLY;
            r_cfg.init    <= RST_INIT;
            r_cfg.fxor    <= RST_FXOR;
            r_cfg.ref_in  <= 1'b1;
            r_cfg.ref_out <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Byte update and finish
    ccrc_byte_step u_step (
        .i_cfg      (r_cfg),
        .i_acc      (r_acc),
        .i_byte     (r_s1_byte),
        .o_acc_next (acc_next),
        .o_checksum (checksum)
    );

    // Advance a valid input stage unless a last byte faces a stalled result register
    assign s1_adv     = r_s1_valid && (!r_s1_eom || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_eom  <= i_in.end_of_message;
        end
    end

    // Accumulator: reload on config write or message end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= RST_INIT;
        end else if (cfg_hit) begin
            r_acc <= start_value(n_cfg);
        end else if (s1_adv) begin
            r_acc <= r_s1_eom ? start_value(r_cfg) : acc_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_eom) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_eom) begin
            r_out_value <= checksum;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.checksum_value = r_out_value;

endmodule

// ===== sv/ccrc_checker.sv =====
// ----------------------------------------------------------------------------
// ccrc_checker
// Port-level checks of the CRC engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ccrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result dropped or changed");

    // Stall input only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without result back-pressure");

    // Leave reset with no result pending
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("result pending right after reset");

endmodule

bind configurable_crc_engine ccrc_checker u_ccrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.checksum_value)
);
